// ===== sv/kcl_pkg.sv =====
// Types, constants and helpers shared by the keypad code lock.
`timescale 1ns / 1ps

package kcl_pkg;

	localparam int unsigned DigitW = 4;
	localparam int unsigned KeyW   = 4;
	localparam int unsigned CountW = 4;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 4;

	localparam logic [DigitW-1:0] DIGIT_BLANK = 4'd10;
	localparam logic [DigitW-1:0] DIGIT_LAST  = 4'd9;

	// key bit positions in a request
	localparam int unsigned KEY1 = 0;
	localparam int unsigned KEY2 = 1;
	localparam int unsigned KEY3 = 2;
	localparam int unsigned KEY4 = 3;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_CODE_FIRST    = 2'd0,
		CFG_CODE_SECOND   = 2'd1,
		CFG_CODE_THIRD    = 2'd2,
		CFG_FAILURE_LIMIT = 2'd3
	} kcl_cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_WELCOME  = 2'd0,
		MODE_ENTRY    = 2'd1,
		MODE_UNLOCKED = 2'd2
	} kcl_mode_t;

	typedef struct packed {
		logic [DigitW-1:0] code_first;
		logic [DigitW-1:0] code_second;
		logic [DigitW-1:0] code_third;
		logic [CountW-1:0] failure_limit;
	} kcl_cfg_t;

	typedef struct packed {
		kcl_mode_t         mode;
		logic [DigitW-1:0] digit_first;
		logic [DigitW-1:0] digit_second;
		logic [DigitW-1:0] digit_third;
		logic [CountW-1:0] failures;
		logic [KeyW-1:0]   pending;
		logic              lamp;
		logic              buzzer;
		logic              page;
	} kcl_state_t;

	typedef struct packed {
		kcl_mode_t         mode;
		logic [DigitW-1:0] digit_first;
		logic [DigitW-1:0] digit_second;
		logic [DigitW-1:0] digit_third;
		logic              lamp_on;
		logic              buzzer_on;
		logic              page_select;
		logic              alarm_pulse;
		logic              reject_pulse;
		logic              unlock_pulse;
		logic [CountW-1:0] failures;
	} kcl_result_t;

	// blank goes to 0, 9 wraps to 0
	function automatic logic [DigitW-1:0] advance_digit(input logic [DigitW-1:0] d);
		logic [DigitW-1:0] r;
		if (d == DIGIT_BLANK || d >= DIGIT_LAST) begin
			r = '0;
		end else begin
			r = d + 4'd1;
		end
		return r;
	endfunction

endpackage

// ===== sv/kcl_if.sv =====
// Valid/ready channel interfaces for key requests and lock results.
`timescale 1ns / 1ps

interface kcl_key_if;
	logic       valid;
	logic       ready;
	logic [3:0] key_presses;

	modport source (output valid, output key_presses, input ready);
	modport sink (input valid, input key_presses, output ready);
endinterface

interface kcl_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [3:0] digit_first;
	logic [3:0] digit_second;
	logic [3:0] digit_third;
	logic       lamp_on;
	logic       buzzer_on;
	logic       page_select;
	logic       alarm_pulse;
	logic       reject_pulse;
	logic       unlock_pulse;
	logic [3:0] failures;

	modport source (
		output valid, output mode, output digit_first, output digit_second,
		output digit_third, output lamp_on, output buzzer_on, output page_select,
		output alarm_pulse, output reject_pulse, output unlock_pulse, output failures,
		input ready
	);
	modport sink (
		input valid, input mode, input digit_first, input digit_second,
		input digit_third, input lamp_on, input buzzer_on, input page_select,
		input alarm_pulse, input reject_pulse, input unlock_pulse, input failures,
		output ready
	);
endinterface

// ===== sv/kcl_step.sv =====
// Combinational update of the lock state for one key request.
`timescale 1ns / 1ps

module kcl_step (
	input  kcl_pkg::kcl_state_t      state,
	input  kcl_pkg::kcl_cfg_t        cfg,
	input  logic [kcl_pkg::KeyW-1:0] keys,
	output kcl_pkg::kcl_state_t      state_next,
	output kcl_pkg::kcl_result_t     result
);

	logic [kcl_pkg::KeyW-1:0]   pend_a;
	logic [kcl_pkg::KeyW-1:0]   pend_b;
	kcl_pkg::kcl_mode_t         mode_a;
	logic [kcl_pkg::DigitW-1:0] d1_b;
	logic [kcl_pkg::DigitW-1:0] d2_b;
	logic [kcl_pkg::DigitW-1:0] d3_b;
	logic                       in_entry;
	logic                       confirm;
	logic                       match;
	logic [kcl_pkg::CountW-1:0] count_inc;
	logic                       limit_hit;

	// welcome: key 4 leaves for entry and the rest falls through this step
	always_comb begin
		pend_a = state.pending | keys;
		mode_a = state.mode;
		if (state.mode == kcl_pkg::MODE_WELCOME && pend_a[kcl_pkg::KEY4]) begin
			mode_a = kcl_pkg::MODE_ENTRY;
			pend_a[kcl_pkg::KEY4] = 1'b0;
		end
	end

	assign in_entry = (mode_a == kcl_pkg::MODE_ENTRY);

	always_comb begin
		pend_b = pend_a;
		d1_b = state.digit_first;
		d2_b = state.digit_second;
		d3_b = state.digit_third;
		if (in_entry) begin
			if (pend_a[kcl_pkg::KEY1]) begin
				d1_b = kcl_pkg::advance_digit(state.digit_first);
			end
			if (pend_a[kcl_pkg::KEY2]) begin
				d2_b = kcl_pkg::advance_digit(state.digit_second);
			end
			if (pend_a[kcl_pkg::KEY3]) begin
				d3_b = kcl_pkg::advance_digit(state.digit_third);
			end
			pend_b[kcl_pkg::KEY3:kcl_pkg::KEY1] = '0;
		end
	end

	assign confirm   = in_entry && pend_b[kcl_pkg::KEY4];
	assign match     = (d1_b == cfg.code_first) && (d2_b == cfg.code_second)
		&& (d3_b == cfg.code_third);
	assign count_inc = state.failures + 4'd1;
	assign limit_hit = (count_inc == cfg.failure_limit);

	// next state
	always_comb begin
		state_next = state;
		state_next.mode = mode_a;
		state_next.pending = pend_b;
		state_next.digit_first = d1_b;
		state_next.digit_second = d2_b;
		state_next.digit_third = d3_b;
		if (confirm) begin
			state_next.pending[kcl_pkg::KEY4] = 1'b0;
			state_next.digit_first = kcl_pkg::DIGIT_BLANK;
			state_next.digit_second = kcl_pkg::DIGIT_BLANK;
			state_next.digit_third = kcl_pkg::DIGIT_BLANK;
			if (match) begin
				state_next.mode = kcl_pkg::MODE_UNLOCKED;
			end else if (limit_hit) begin
				state_next.failures = '0;
			end else begin
				state_next.failures = count_inc;
			end
		end else if (mode_a == kcl_pkg::MODE_UNLOCKED) begin
			// key 3 is left pending here
			if (pend_b[kcl_pkg::KEY1]) begin
				state_next.lamp = ~state.lamp;
			end
			if (pend_b[kcl_pkg::KEY2]) begin
				state_next.buzzer = ~state.buzzer;
			end
			if (pend_b[kcl_pkg::KEY4]) begin
				state_next.page = ~state.page;
			end
			state_next.pending[kcl_pkg::KEY1] = 1'b0;
			state_next.pending[kcl_pkg::KEY2] = 1'b0;
			state_next.pending[kcl_pkg::KEY4] = 1'b0;
		end
	end

	// result fields
	always_comb begin
		result.mode = state_next.mode;
		result.digit_first = state_next.digit_first;
		result.digit_second = state_next.digit_second;
		result.digit_third = state_next.digit_third;
		result.lamp_on = state_next.lamp;
		result.buzzer_on = state_next.buzzer;
		result.page_select = state_next.page;
		result.alarm_pulse = confirm && !match && limit_hit;
		result.reject_pulse = confirm && !match && !limit_hit;
		result.unlock_pulse = confirm && match;
		result.failures = state_next.failures;
	end

endmodule

// ===== sv/keypad_code_lock.sv =====
// Keypad code lock: registered input stage, update logic and result register.
//
// Usage: key press requests enter on the key channel (valid/ready, field
// key_presses, bit 0 key 1 up to bit 3 key 4). Each request yields exactly one
// result on the res channel: mode, the three entered digits (10 is blank), the
// lamp, buzzer and page toggles, the alarm/reject/unlock pulses and the
// failure count, all as they stand after that request.
// A request is captured in the input register and its result is then held
// in the result register. One request per cycle is sustained while the
// receiver does not stall; the update of the lock state is combinational
// logic from the input register into the state and result registers.
// A stalled receiver holds the result register; the input register then
// holds too and key.ready drops once both are full.
// Reset clears both stages, sets welcome mode, blank digits, zero failures,
// no pending keys, toggles off, and the code registers to 1, 2, 3 with a
// failure limit of 3. Configuration writes (cfg_we, cfg_index, cfg_wdata) are
// taken at any edge and are meant for when the block is idle.
`timescale 1ns / 1ps

module keypad_code_lock (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [kcl_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [kcl_pkg::CfgDataW-1:0]   cfg_wdata,
	kcl_key_if.sink                        key,
	kcl_res_if.source                      res
);

	kcl_pkg::kcl_cfg_t    cfg_q;
	kcl_pkg::kcl_state_t  state_q;
	kcl_pkg::kcl_state_t  state_next;
	kcl_pkg::kcl_result_t result_comb;
	kcl_pkg::kcl_result_t result_s2;
	logic                 valid_s2;
	logic [kcl_pkg::KeyW-1:0] keys_s1;
	logic                 valid_s1;
	logic                 adv_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.code_first <= 4'd1;
			cfg_q.code_second <= 4'd2;
			cfg_q.code_third <= 4'd3;
			cfg_q.failure_limit <= 4'd3;
		end else if (cfg_we) begin
			unique case (kcl_pkg::kcl_cfg_idx_t'(cfg_index))
				kcl_pkg::CFG_CODE_FIRST:    cfg_q.code_first <= cfg_wdata;
				kcl_pkg::CFG_CODE_SECOND:   cfg_q.code_second <= cfg_wdata;
				kcl_pkg::CFG_CODE_THIRD:    cfg_q.code_third <= cfg_wdata;
				kcl_pkg::CFG_FAILURE_LIMIT: cfg_q.failure_limit <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// advance stage 1 when the result register is free or being drained
	assign adv_s1    = valid_s1 && (!valid_s2 || res.ready);
	assign key.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key.ready) begin
			valid_s1 <= key.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key.ready && key.valid) begin
			keys_s1 <= key.key_presses;
		end
	end

	kcl_step u_step (
		.state      (state_q),
		.cfg        (cfg_q),
		.keys       (keys_s1),
		.state_next (state_next),
		.result     (result_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode <= kcl_pkg::MODE_WELCOME;
			state_q.digit_first <= kcl_pkg::DIGIT_BLANK;
			state_q.digit_second <= kcl_pkg::DIGIT_BLANK;
			state_q.digit_third <= kcl_pkg::DIGIT_BLANK;
			state_q.failures <= '0;
			state_q.pending <= '0;
			state_q.lamp <= 1'b0;
			state_q.buzzer <= 1'b0;
			state_q.page <= 1'b0;
		end else if (adv_s1) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= result_comb;
		end
	end

	assign res.valid        = valid_s2;
	assign res.mode         = result_s2.mode;
	assign res.digit_first  = result_s2.digit_first;
	assign res.digit_second = result_s2.digit_second;
	assign res.digit_third  = result_s2.digit_third;
	assign res.lamp_on      = result_s2.lamp_on;
	assign res.buzzer_on    = result_s2.buzzer_on;
	assign res.page_select  = result_s2.page_select;
	assign res.alarm_pulse  = result_s2.alarm_pulse;
	assign res.reject_pulse = result_s2.reject_pulse;
	assign res.unlock_pulse = result_s2.unlock_pulse;
	assign res.failures     = result_s2.failures;

	a_one_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $onehot0({result_s2.alarm_pulse, result_s2.reject_pulse,
			result_s2.unlock_pulse}))
		else $error("more than one outcome pulse in a result");

	a_unlock_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.unlock_pulse) |-> result_s2.mode == kcl_pkg::MODE_UNLOCKED)
		else $error("unlock pulse without unlocked mode");

	a_alarm_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.alarm_pulse) |-> result_s2.failures == '0)
		else $error("alarm pulse did not clear the failure count");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(state_q))
		else $error("lock state changed without a request advancing");

endmodule
